### hw/rtl/particle_cull_depth_sort_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle cull and depth sort block
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_CULL_DEPTH_SORT_ASSERT_SVH
`define PARTICLE_CULL_DEPTH_SORT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcds check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcds check failed");

`endif

### hw/rtl/pcds_pkg.sv
// ----------------------------------------------------------------------------
// Particle cull and depth sort package
// Field widths, register indexes and the cull unit's request and status types.
// ----------------------------------------------------------------------------
package pcds_pkg;

  localparam int DIST_W     = 32;
  localparam int PIX_W      = 32;
  localparam int SCALE_W    = 16;
  localparam int TAG_W      = 8;
  localparam int NUM_OUT_W  = 6;
  localparam int BASE_W     = 32;
  localparam int SMOOTH_W   = 16;
  localparam int THIN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF_BASE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF_SMOOTHING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THINNING_FACTOR   = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [SCALE_W-1:0] scale;
    logic [TAG_W-1:0]   tag;
    logic [THIN_W-1:0]  thin;
    logic               thin_on;
  } cull_req_t;

  typedef struct packed {
    logic done;
    logic culled;
  } cull_rsp_t;

endpackage

### hw/rtl/pcds_if.sv
// ----------------------------------------------------------------------------
// Particle cull and depth sort channel interfaces
// Valid/ready channels for particles in, sorted numbers out, and register writes.
// ----------------------------------------------------------------------------
interface pcds_in_if;
  import pcds_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  view_distance;
  logic [PIX_W-1:0]   pixel_size;
  logic [SCALE_W-1:0] falloff_scale;
  logic [TAG_W-1:0]   tag;
  logic               final_particle;

  modport source (output valid, view_distance, pixel_size, falloff_scale, tag,
                  final_particle, input ready);
  modport sink (input valid, view_distance, pixel_size, falloff_scale, tag,
                final_particle, output ready);
endinterface

interface pcds_out_if;
  import pcds_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [NUM_OUT_W-1:0] particle_number;
  logic                 survivor;
  logic                 end_of_list;

  modport source (output valid, particle_number, survivor, end_of_list, input ready);
  modport sink (input valid, particle_number, survivor, end_of_list, output ready);
endinterface

interface pcds_cfg_if;
  import pcds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pcds_cull.sv
// ----------------------------------------------------------------------------
// Particle cull unit
// Pixel-size falloff compare and a bit-serial tag remainder over the tag's eight bits.
// ----------------------------------------------------------------------------
module pcds_cull (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  pcds_pkg::cull_req_t        req,
  input  logic [pcds_pkg::BASE_W-1:0]   falloff_base,
  input  logic [pcds_pkg::SMOOTH_W-1:0] falloff_smoothing,
  output pcds_pkg::cull_rsp_t        rsp
);
  import pcds_pkg::*;

  localparam int A_W    = BASE_W + SMOOTH_W + 1;
  localparam int PROD_W = A_W - 1 + SCALE_W;
  localparam int STEP_W = $clog2(TAG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TAG_W - 1);

  logic [A_W-1:0]    a_r;
  logic [PROD_W-1:0] prod_r;
  logic              a_big_r;
  cull_req_t         req_fix;
  cull_req_t         req_r;
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [THIN_W-1:0] rem_r;
  logic [THIN_W-1:0] rem_nxt;
  logic [THIN_W:0]   rem_shift;
  logic              too_small;

  // Threshold level depends only on configuration, so it is kept ready ahead of any particle.
  always_ff @(posedge clk) begin
    a_r <= A_W'(falloff_base) * A_W'({1'b0, falloff_smoothing} + (SMOOTH_W + 1)'(256));
  end

  // A thinning factor of zero behaves as one.
  always_comb begin
    req_fix = req;
    if (req.thin == '0) begin
      req_fix.thin = THIN_W'(1);
    end
  end

  always_comb begin
    rem_shift = {rem_r, req_r.tag[LAST_STEP - step_r]};
    if (rem_shift >= {1'b0, req_r.thin}) begin
      rem_nxt = THIN_W'(rem_shift - {1'b0, req_r.thin});
    end else begin
      rem_nxt = rem_shift[THIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= req_fix;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      if (step_r == '0) begin
        prod_r  <= PROD_W'(a_r[A_W-2:0]) * PROD_W'(req_r.scale);
        a_big_r <= a_r[A_W-1];
      end
    end
  end

  // Both sides of the compare carry 32 fraction bits.
  always_comb begin
    if (req_r.scale == '0) begin
      too_small = (req_r.pix != '0);
    end else begin
      too_small = !a_big_r && (PROD_W'({req_r.pix, 16'h0000}) > prod_r);
    end
  end

  assign rsp.done   = busy_r && (step_r == LAST_STEP);
  assign rsp.culled = too_small || (req_r.thin_on && (rem_nxt != '0));

endmodule

### hw/rtl/particle_cull_depth_sort.sv
// ----------------------------------------------------------------------------
// Particle cull and back-to-front sort
// Culls particles by pixel-size falloff and tag thinning, keeps the survivors
// in a distance-sorted list memory and streams their numbers farthest first.
// ----------------------------------------------------------------------------
// One particle is handled at a time. The cull test runs the eight-step tag
// remainder, and a survivor is then placed by an insertion walk through the
// list memory, one entry per cycle, that moves each already stored survivor
// nearer than it down by one entry. On the final particle each sorted number
// is read from the list memory and offered in turn, the next one being read
// only after the sink has taken the one before; no new particle is taken
// until the last number of the list has been delivered.
module particle_cull_depth_sort #(
  parameter int unsigned MAX_PARTICLES     = 64,
  parameter int unsigned THIN_EXEMPT_LIMIT = 10
) (
  input logic        clk,
  input logic        rst_n,
  pcds_in_if.sink    in_if,
  pcds_out_if.source out_if,
  pcds_cfg_if.sink   cfg_if
);
  import pcds_pkg::*;

  localparam int NUM_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CULL    = 6'b000010,
    S_INSERT  = 6'b000100,
    S_EMIT_GO = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_WT = 6'b100000
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [NUM_W-1:0]  num;
  } entry_t;

  state_t state_r;

  logic [BASE_W-1:0]   base_r;
  logic [SMOOTH_W-1:0] smooth_r;
  logic [THIN_W-1:0]   thin_r;

  logic [CNT_W-1:0]  arr_cnt_r;
  logic [CNT_W-1:0]  surv_cnt_r;
  logic [DIST_W-1:0] key_dist_r;
  logic [NUM_W-1:0]  key_num_r;
  logic              final_r;
  logic              room_r;
  logic [NUM_W-1:0]  j_r;
  logic [NUM_W-1:0]  k_r;

  logic [NUM_OUT_W-1:0] out_num_r;
  logic                 out_surv_r;
  logic                 out_eol_r;
  logic                 out_valid_r;

  entry_t list_mem [MAX_PARTICLES];
  entry_t rd_data_r;
  logic             mem_we;
  logic [NUM_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [NUM_W-1:0] mem_raddr;

  logic      in_fire;
  logic      out_fire;
  logic      survive;
  logic      shift;
  cull_req_t cull_req;
  cull_rsp_t cull_rsp;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_valid_r && out_if.ready;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid           = out_valid_r;
  assign out_if.particle_number = out_num_r;
  assign out_if.survivor        = out_surv_r;
  assign out_if.end_of_list     = out_eol_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_W'(65536);
      smooth_r <= '0;
      thin_r   <= THIN_W'(1);
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_FALLOFF_BASE:      base_r   <= cfg_if.data[BASE_W-1:0];
        CFG_FALLOFF_SMOOTHING: smooth_r <= cfg_if.data[SMOOTH_W-1:0];
        CFG_THINNING_FACTOR:   thin_r   <= cfg_if.data[THIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cull_req.pix     = in_if.pixel_size;
    cull_req.scale   = in_if.falloff_scale;
    cull_req.tag     = in_if.tag;
    cull_req.thin    = thin_r;
    cull_req.thin_on = 32'(arr_cnt_r) > 32'(THIN_EXEMPT_LIMIT);
  end

  pcds_cull u_cull (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (in_fire),
    .req               (cull_req),
    .falloff_base      (base_r),
    .falloff_smoothing (smooth_r),
    .rsp               (cull_rsp)
  );

  assign survive = room_r && !cull_rsp.culled;
  assign shift   = (j_r != '0) && (rd_data_r.distance < key_dist_r);

  // List memory port control. The insertion walk writes entry j while reading
  // entry j-2, so the two ports never meet on one entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = j_r;
    mem_wdata = '{distance: key_dist_r, num: key_num_r};
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_CULL: begin
        if (cull_rsp.done && survive && (surv_cnt_r != '0)) begin
          mem_re    = 1'b1;
          mem_raddr = NUM_W'(surv_cnt_r - CNT_W'(1));
        end
      end
      S_INSERT: begin
        mem_we = 1'b1;
        if (shift) begin
          mem_wdata = rd_data_r;
          if (j_r != NUM_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = j_r - NUM_W'(2);
          end
        end
      end
      S_EMIT_GO: begin
        if (surv_cnt_r != '0) begin
          mem_re = 1'b1;
        end
      end
      S_EMIT_WT: begin
        if (out_fire && !out_eol_r) begin
          mem_re    = 1'b1;
          mem_raddr = k_r + NUM_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= list_mem[mem_raddr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arr_cnt_r   <= '0;
      surv_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (arr_cnt_r < CNT_W'(MAX_PARTICLES)) begin
              arr_cnt_r <= arr_cnt_r + CNT_W'(1);
            end
            state_r <= S_CULL;
          end
        end
        S_CULL: begin
          if (cull_rsp.done) begin
            if (survive) begin
              state_r <= S_INSERT;
            end else if (final_r) begin
              state_r <= S_EMIT_GO;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_INSERT: begin
          if (!shift) begin
            surv_cnt_r <= surv_cnt_r + CNT_W'(1);
            state_r    <= final_r ? S_EMIT_GO : S_IDLE;
          end
        end
        S_EMIT_GO: begin
          if (surv_cnt_r == '0) begin
            out_valid_r <= 1'b1;
            state_r     <= S_EMIT_WT;
          end else begin
            state_r <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_EMIT_WT;
        end
        S_EMIT_WT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            if (out_eol_r) begin
              arr_cnt_r  <= '0;
              surv_cnt_r <= '0;
              state_r    <= S_IDLE;
            end else begin
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_dist_r <= in_if.view_distance;
          key_num_r  <= arr_cnt_r[NUM_W-1:0];
          final_r    <= in_if.final_particle;
          room_r     <= arr_cnt_r < CNT_W'(MAX_PARTICLES);
        end
      end
      S_CULL: begin
        j_r <= surv_cnt_r[NUM_W-1:0];
      end
      S_INSERT: begin
        if (shift) begin
          j_r <= j_r - NUM_W'(1);
        end
      end
      S_EMIT_GO: begin
        k_r        <= '0;
        out_num_r  <= '0;
        out_surv_r <= 1'b0;
        out_eol_r  <= 1'b1;
      end
      S_EMIT_RD: begin
        out_num_r  <= NUM_OUT_W'(rd_data_r.num);
        out_surv_r <= 1'b1;
        out_eol_r  <= (CNT_W'(k_r) + CNT_W'(1)) == surv_cnt_r;
      end
      S_EMIT_WT: begin
        if (out_fire && !out_eol_r) begin
          k_r <= k_r + NUM_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/pcds_checker.sv
// ----------------------------------------------------------------------------
// Particle cull and depth sort port checker
// Watches the top level's channels for ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "particle_cull_depth_sort_assert.svh"

module pcds_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_survivor,
  input logic out_end_of_list
);

  // A result that is offered stays offered until it is taken.
  `PCDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // No particle is taken while the sorted list is being delivered.
  `PCDS_ASSERT_NOW(a_no_in_during_out, clk, rst_n, out_valid, !in_ready)

  // The empty-set result is always the only and last one.
  `PCDS_ASSERT_NOW(a_empty_is_last, clk, rst_n, out_valid && !out_survivor, out_end_of_list)

  // Once the last number of a list is taken, nothing more is offered.
  `PCDS_ASSERT_NEXT(a_list_ends, clk, rst_n, out_valid && out_ready && out_end_of_list,
                    !out_valid)

endmodule

bind particle_cull_depth_sort pcds_checker u_pcds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_survivor    (out_if.survivor),
  .out_end_of_list (out_if.end_of_list)
);

### tb/sv/tb_particle_cull_depth_sort.sv
// ----------------------------------------------------------------------------
// Particle cull and depth sort testbench
// Drives sets of particles through the block, predicts which particles survive
// the falloff and thinning tests, and checks the farthest-first list of numbers
// against that prediction. The run moves through several register settings
// and several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_particle_cull_depth_sort;
  timeunit 1ns;
  timeprecision 1ps;
  import pcds_pkg::*;

  localparam int MAX_PARTICLES     = 64;
  localparam int THIN_EXEMPT_LIMIT = 10;
  localparam int QUIET_LIMIT       = 5000;
  localparam int DRAIN_CYCLES      = 100;

  typedef struct packed {
    logic [NUM_OUT_W-1:0] number;
    logic                 survivor;
    logic                 end_of_list;
  } sorted_entry_t;

  // Keeps its own copy of the registers and the particle store, and queues
  // the sorted list that each final particle should produce.
  class particle_scoreboard;
    logic [BASE_W-1:0]   base;
    logic [SMOOTH_W-1:0] smooth;
    logic [THIN_W-1:0]   thin;
    logic [DIST_W-1:0]   dist_mem [MAX_PARTICLES];
    int unsigned         kept_num [MAX_PARTICLES];
    int unsigned         arrivals;
    int unsigned         kept;
    sorted_entry_t       expected_list [$];
    int                  errors;

    function new();
      base     = 32'h0001_0000;
      smooth   = '0;
      thin     = 8'd1;
      arrivals = 0;
      kept     = 0;
      errors   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FALLOFF_BASE:      base = data[BASE_W-1:0];
        CFG_FALLOFF_SMOOTHING: smooth = data[SMOOTH_W-1:0];
        CFG_THINNING_FACTOR:   thin = data[THIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_culled(logic [PIX_W-1:0] pix, logic [SCALE_W-1:0] scale,
                           int unsigned number, logic [TAG_W-1:0] tag);
      logic [63:0]       lhs;
      logic [63:0]       gain;
      logic [THIN_W-1:0] tf;
      bit                too_small;
      lhs  = {16'b0, pix, 16'b0};
      gain = 64'(base) * (64'd256 + 64'(smooth));
      tf   = (thin == '0) ? 8'd1 : thin;
      if (scale == '0) begin
        too_small = (lhs != 0);
      end else if (gain >= 64'h0001_0000_0000_0000) begin
        too_small = 1'b0;
      end else begin
        too_small = (lhs > gain * 64'(scale));
      end
      return too_small || ((tag % tf) != 0 && number > THIN_EXEMPT_LIMIT);
    endfunction

    function void note_particle(logic [DIST_W-1:0] distance, logic [PIX_W-1:0] pix,
                                logic [SCALE_W-1:0] scale, logic [TAG_W-1:0] tag,
                                logic final_particle);
      int unsigned   key;
      int            j;
      sorted_entry_t queued;
      if (arrivals < MAX_PARTICLES) begin
        dist_mem[arrivals] = distance;
        if (!is_culled(pix, scale, arrivals, tag) && kept < MAX_PARTICLES) begin
          kept_num[kept] = arrivals;
          kept++;
        end
        arrivals++;
      end
      if (!final_particle) return;
      if (kept == 0) begin
        queued = '{number: '0, survivor: 1'b0, end_of_list: 1'b1};
        expected_list.insert(expected_list.size(), queued);
      end else begin
        // Stable insertion sort, farthest first; equal distances keep arrival order.
        for (int i = 1; i < kept; i++) begin
          key = kept_num[i];
          j   = i;
          while (j > 0 && dist_mem[kept_num[j-1]] < dist_mem[key]) begin
            kept_num[j] = kept_num[j-1];
            j--;
          end
          kept_num[j] = key;
        end
        for (int k = 0; k < kept; k++) begin
          queued = '{number: NUM_OUT_W'(kept_num[k]), survivor: 1'b1,
                     end_of_list: (k == kept - 1)};
          expected_list.insert(expected_list.size(), queued);
        end
      end
      arrivals = 0;
      kept     = 0;
    endfunction

    function void check_result(logic [NUM_OUT_W-1:0] number, logic survivor,
                               logic end_of_list);
      sorted_entry_t want;
      if (expected_list.size() == 0) begin
        $error("unexpected result: particle_number %0d survivor %0b end_of_list %0b",
               number, survivor, end_of_list);
        errors++;
        return;
      end
      want = expected_list.pop_front();
      if (number !== want.number) begin
        $error("particle_number mismatch: expected %0d, got %0d", want.number, number);
        errors++;
      end
      if (survivor !== want.survivor) begin
        $error("survivor mismatch: expected %0b, got %0b", want.survivor, survivor);
        errors++;
      end
      if (end_of_list !== want.end_of_list) begin
        $error("end_of_list mismatch: expected %0b, got %0b", want.end_of_list,
               end_of_list);
        errors++;
      end
    endfunction

    function int pending();
      return expected_list.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pcds_in_if  in_ch();
  pcds_out_if out_ch();
  pcds_cfg_if cfg_ch();

  particle_cull_depth_sort #(
    .MAX_PARTICLES    (MAX_PARTICLES),
    .THIN_EXEMPT_LIMIT(THIN_EXEMPT_LIMIT)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  particle_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result sink: ready changes on the falling edge at the current stall rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.particle_number, out_ch.survivor, out_ch.end_of_list);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // All driving tasks are entered and left on a falling edge.
  task automatic send_particle(input logic [DIST_W-1:0] distance,
                               input logic [PIX_W-1:0] pix,
                               input logic [SCALE_W-1:0] scale, input logic [TAG_W-1:0] tag,
                               input logic final_particle);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.view_distance  = distance;
    in_ch.pixel_size     = pix;
    in_ch.falloff_scale  = scale;
    in_ch.tag            = tag;
    in_ch.final_particle = final_particle;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_particle(distance, pix, scale, tag, final_particle);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Holds the sender off until every expected number has come out; with a tail,
  // also lets the block finish any particle that produced no result.
  task automatic settle(input bit with_tail);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    if (with_tail) repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One set of particles, the last one carrying the final mark. With keep_all
  // every particle passes both tests, so a long enough set fills the store to capacity.
  task automatic run_set(input int count, input bit keep_all);
    logic [DIST_W-1:0]  distance;
    logic [PIX_W-1:0]   pix;
    logic [SCALE_W-1:0] scale;
    logic [TAG_W-1:0]   tag;
    logic [THIN_W-1:0]  tf;
    logic [63:0]        gain;
    logic [63:0]        limit;
    tf   = (sb.thin == '0) ? 8'd1 : sb.thin;
    gain = 64'(sb.base) * (64'd256 + 64'(sb.smooth));
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: distance = 32'($urandom_range(3)) << 8;
        1: distance = $urandom_range(1) ? '1 : '0;
        default: distance = $urandom();
      endcase
      case ($urandom_range(9))
        0: scale = '0;
        1: scale = '1;
        default: scale = 16'($urandom_range(65535));
      endcase
      if (keep_all) begin
        pix = '0;
      end else begin
        case ($urandom_range(3))
          0: pix = '0;
          1: pix = $urandom();
          default: begin
            // Land on either side of the falloff threshold.
            if (scale == '0 || gain >= 64'h0001_0000_0000_0000) begin
              pix = $urandom();
            end else begin
              limit = (gain * 64'(scale)) >> 16;
              if (limit > 64'hFFFF_FFFF) pix = $urandom();
              else pix = limit[31:0] + 32'($urandom_range(2)) - 32'd1;
            end
          end
        endcase
      end
      if (keep_all) tag = '0;
      else if ($urandom_range(1)) tag = 8'(tf * $urandom_range(255 / tf));
      else tag = 8'($urandom());
      send_particle(distance, pix, scale, tag, n == count - 1);
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    in_ch.valid          = 1'b0;
    in_ch.view_distance  = '0;
    in_ch.pixel_size     = '0;
    in_ch.falloff_scale  = '0;
    in_ch.tag            = '0;
    in_ch.final_particle = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FALLOFF_BASE;
    cfg_ch.data  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: a zero scale culls any nonzero pixel size but keeps a zero one,
    // the threshold itself survives and one step above it is culled.
    send_particle(32'hFFFF_FFFF, 32'h0, 16'h0, 8'hFF, 1'b0);
    send_particle(32'h0, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1'b0);
    send_particle(32'h100, 32'h0000_4000, 16'h0040, 8'h01, 1'b0);
    send_particle(32'h100, 32'h0000_4001, 16'h0040, 8'h02, 1'b0);
    send_particle(32'h5, 32'h1, 16'h0, 8'h03, 1'b1);
    // A set in which nothing survives.
    send_particle(32'h77, 32'hFFFF_FFFF, 16'h1, 8'h00, 1'b1);

    // Huge falloff gain disables the size test for a nonzero scale; thinning by three
    // only bites past the exempt numbers.
    settle(1'b1);
    write_register(CFG_FALLOFF_BASE, 32'hFFFF_FFFF);
    write_register(CFG_FALLOFF_SMOOTHING, 32'h0000_FFFF);
    write_register(CFG_THINNING_FACTOR, 32'd3);
    for (int n = 0; n < 13; n++) begin
      send_particle((n == 5) ? 32'hFFFF_FFFF : 32'(n % 3),
                    (n == 7) ? 32'h1 : 32'hFFFF_FFFF,
                    (n == 7) ? 16'h0 : 16'(n * 1000 + 1),
                    (n == 11) ? 8'd4 : 8'(3 * n + ((n == 5 || n == 10) ? 1 : 0)),
                    n == 12);
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle(1'b1);
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          write_register(CFG_FALLOFF_BASE, 32'($urandom_range(32'h4_0000, 32'h8000)));
          write_register(CFG_FALLOFF_SMOOTHING, 32'($urandom_range(255)));
          write_register(CFG_THINNING_FACTOR, 32'd1);
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 0;
          write_register(CFG_FALLOFF_BASE, 32'hFFFF_FFFF);
          write_register(CFG_FALLOFF_SMOOTHING, 32'd0);
          write_register(CFG_THINNING_FACTOR, 32'd0);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 80;
          write_register(CFG_FALLOFF_BASE, 32'd0);
          write_register(CFG_FALLOFF_SMOOTHING, 32'h0000_FFFF);
          write_register(CFG_THINNING_FACTOR, 32'd255);
        end
        default: begin
          idle_pct  = 17;
          stall_pct = 17;
          write_register(CFG_FALLOFF_BASE, $urandom());
          write_register(CFG_FALLOFF_SMOOTHING, 32'($urandom_range(65535)));
          write_register(CFG_THINNING_FACTOR, 32'($urandom_range(7, 2)));
        end
      endcase
      // A set longer than the store: the first 64 fill it, the rest are dropped.
      if (ph == 0) run_set(70, 1'b1);
      while (items_sent < 20 + 75 * (ph + 1)) begin
        if ($urandom_range(7) == 0) settle(1'b0);
        run_set(($urandom_range(9) == 0) ? $urandom_range(50, 20) : $urandom_range(14, 1),
                1'b0);
      end
    end

    settle(1'b1);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### particle_cull_depth_sort.f
+incdir+hw/rtl
hw/rtl/pcds_pkg.sv
hw/rtl/pcds_if.sv
hw/rtl/pcds_cull.sv
hw/rtl/particle_cull_depth_sort.sv
hw/rtl/pcds_checker.sv
tb/sv/tb_particle_cull_depth_sort.sv
